[design/sha_pkg.sv]
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int HASH_WORDS  = 8;
    localparam int IDX_W       = $clog2(HASH_WORDS);

    // fill level of the last byte of a block, and the start of the length field
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0] LEN_START = FILL_W'(BLOCK_BYTES - 8);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HASH_WORDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_VECTOR [HASH_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // source of a byte shifted into the block buffer
    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                 shift_en;
        byte_sel_t            byte_sel;
        logic [2:0]           len_sel;
        logic                 count_byte;
        logic                 load_wv;
        logic                 wk_en;
        logic [ROUND_W-1:0]   sched_idx;
        logic                 round_en;
        logic                 add_hash;
        logic                 init_hash;
        logic                 out_valid;
        logic [IDX_W-1:0]     out_idx;
        logic                 out_last;
    } sha_cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[design/sha_in_if.sv]
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                    output ready);
endinterface

[design/sha_out_if.sv]
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

[design/sha256_stream_hasher_top.sv]
// Channel  Dir  Payload                                  Transfer
// in_ch    in   data_byte[7:0], has_byte, last_byte      valid && ready
// out_ch   out  digest_word[31:0], word_index[2:0],      valid && ready
//               last_word
//
// The 64th byte of a block starts a compression (load, 64 rounds on the one
// round unit, chaining add).
// A last item pads one byte per cycle, outside compression, up to the block end,
// with an idle ST_PAD_ZERO step before the length field, compressing once or twice,
// then shows the eight digest words, one per cycle while out_ch.ready.
// in_ch.ready is low during compression, padding and digest output.
// Reset loads the initial vector and clears the fill and length counts.
module sha256_stream_hasher_top (
    input logic        clk,
    input logic        rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    sha_pkg::sha_cmd_t cmd;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_has    (in_ch.has_byte),
        .in_last   (in_ch.last_byte),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    sha_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .digest_word (out_ch.digest_word)
    );

    assign out_ch.valid      = cmd.out_valid;
    assign out_ch.word_index = cmd.out_idx;
    assign out_ch.last_word  = cmd.out_last;

    // input and output never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input ready during digest output");

    // byte loading and rounds share the window
    a_window_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_en && cmd.round_en))
        else $error("shift and round in the same cycle");

    // digest words come out in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_word) |=>
        (out_ch.valid && out_ch.word_index == 3'($past(out_ch.word_index) + 3'd1)))
        else $error("digest word order broken");

    // after the final word the block takes input again
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_word) |=> in_ch.ready)
        else $error("not idle after digest");

endmodule

[design/sha_ctrl.sv]
module sha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_has,
    input  logic              in_last,
    output logic              in_ready,
    input  logic              out_ready,
    output sha_pkg::sha_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [sha_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [sha_pkg::ROUND_W-1:0]  rnd_reg, rnd_next;
    logic [sha_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                         last_pend_reg, last_pend_next;
    logic                         mark_done_reg, mark_done_next;
    logic                         final_reg, final_next;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        mark_done_next = mark_done_reg;
        final_next     = final_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = sha_pkg::BYTE_DATA;
        cmd.len_sel    = fill_reg[2:0];
        cmd.out_idx    = idx_reg;
        cmd.out_last   = (idx_reg == sha_pkg::IDX_LAST);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_has)
                    begin
                        cmd.shift_en   = 1'b1;
                        cmd.count_byte = 1'b1;
                        fill_next      = fill_reg + 1'b1;
                        if (fill_reg == sha_pkg::FILL_LAST)
                        begin
                            last_pend_next = in_last;
                            state_next     = ST_LOAD;
                        end
                        else if (in_last)
                        begin
                            state_next = ST_PAD_MARK;
                        end
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_wv   = 1'b1;
                cmd.wk_en     = 1'b1;
                cmd.sched_idx = '0;
                rnd_next      = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en  = 1'b1;
                cmd.wk_en     = 1'b1;
                cmd.sched_idx = rnd_reg + 1'b1;
                rnd_next      = rnd_reg + 1'b1;
                if (rnd_reg == sha_pkg::ROUND_LAST)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_hash = 1'b1;
                priority if (final_reg)
                    state_next = ST_OUT;
                else if (last_pend_reg && mark_done_reg)
                    state_next = ST_PAD_ZERO;
                else if (last_pend_reg)
                    state_next = ST_PAD_MARK;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD_MARK:
            begin
                cmd.shift_en   = 1'b1;
                cmd.byte_sel   = sha_pkg::BYTE_MARK;
                fill_next      = fill_reg + 1'b1;
                last_pend_next = 1'b1;
                mark_done_next = 1'b1;
                state_next     = (fill_reg == sha_pkg::FILL_LAST) ? ST_LOAD : ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == sha_pkg::LEN_START)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = sha_pkg::BYTE_ZERO;
                    fill_next    = fill_reg + 1'b1;
                    if (fill_reg == sha_pkg::FILL_LAST)
                        state_next = ST_LOAD;
                end
            end
            ST_PAD_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha_pkg::BYTE_LEN;
                fill_next    = fill_reg + 1'b1;
                if (fill_reg == sha_pkg::FILL_LAST)
                begin
                    final_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                cmd.out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == sha_pkg::IDX_LAST)
                    begin
                        cmd.init_hash  = 1'b1;
                        last_pend_next = 1'b0;
                        mark_done_next = 1'b0;
                        final_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            mark_done_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
            mark_done_reg <= mark_done_next;
            final_reg     <= final_next;
        end
    end

endmodule

[design/sha_datapath.sv]
module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic [7:0]        data_byte,
    output logic [31:0]       digest_word
);

    localparam int BB = sha_pkg::BLOCK_BITS;

    logic [BB-1:0] blk_reg;
    logic [31:0]   wk_reg;
    logic [31:0]   wv_reg   [sha_pkg::HASH_WORDS];
    logic [31:0]   hash_reg [sha_pkg::HASH_WORDS];
    logic [63:0]   bits_reg;

    logic [7:0]    byte_in;
    logic [31:0]   w_new;
    logic [31:0]   t1, t2;

    // byte fed into the block buffer
    always_comb
    begin
        unique case (cmd.byte_sel)
            sha_pkg::BYTE_DATA: byte_in = data_byte;
            sha_pkg::BYTE_MARK: byte_in = sha_pkg::PAD_MARK;
            sha_pkg::BYTE_ZERO: byte_in = 8'h00;
            sha_pkg::BYTE_LEN:  byte_in = 8'(bits_reg >> {3'd7 - cmd.len_sel, 3'b000});
            default:            byte_in = 8'h00;
        endcase
    end

    // schedule word: the top of the window holds W[t-16], or W[t] in the first 16
    always_comb
    begin
        if (cmd.sched_idx < 6'd16)
            w_new = blk_reg[BB-1 -: 32];
        else
            w_new = sha_pkg::small_sig1(blk_reg[BB-1-32*14 -: 32]) +
                    blk_reg[BB-1-32*9 -: 32] +
                    sha_pkg::small_sig0(blk_reg[BB-1-32*1 -: 32]) +
                    blk_reg[BB-1 -: 32];
    end

    // round function
    always_comb
    begin
        t1 = wv_reg[7] + sha_pkg::big_sig1(wv_reg[4]) +
             (wv_reg[6] ^ (wv_reg[4] & (wv_reg[5] ^ wv_reg[6]))) + wk_reg;
        t2 = sha_pkg::big_sig0(wv_reg[0]) +
             ((wv_reg[0] & wv_reg[1]) | ((wv_reg[0] | wv_reg[1]) & wv_reg[2]));
    end

    // block buffer doubles as the schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
            blk_reg <= {blk_reg[BB-9:0], byte_in};
        else if (cmd.wk_en)
            blk_reg <= {blk_reg[BB-33:0], w_new};
        if (cmd.wk_en)
            wk_reg <= w_new + sha_pkg::ROUND_K[cmd.sched_idx];
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_wv)
        begin
            for (int j = 0; j < sha_pkg::HASH_WORDS; j++)
                wv_reg[j] <= hash_reg[j];
        end
        else if (cmd.round_en)
        begin
            for (int j = 1; j < sha_pkg::HASH_WORDS; j++)
                wv_reg[j] <= wv_reg[j-1];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[0] <= t1 + t2;
        end
    end

    // chaining state and bit length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < sha_pkg::HASH_WORDS; j++)
                hash_reg[j] <= sha_pkg::INIT_VECTOR[j];
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.init_hash)
            begin
                for (int j = 0; j < sha_pkg::HASH_WORDS; j++)
                    hash_reg[j] <= sha_pkg::INIT_VECTOR[j];
                bits_reg <= '0;
            end
            else
            begin
                if (cmd.add_hash)
                begin
                    for (int j = 0; j < sha_pkg::HASH_WORDS; j++)
                        hash_reg[j] <= hash_reg[j] + wv_reg[j];
                end
                if (cmd.count_byte)
                    bits_reg <= bits_reg + 64'd8;
            end
        end
    end

    assign digest_word = hash_reg[cmd.out_idx];

endmodule

[tb/sv/tb_sha_channels.sv]
`timescale 1ns / 1ps

// Stimulus-side byte transfer record used by the testbench.
typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
} byte_xfer_t;

[tb/sv/tb_sha256_stream_hasher_top.sv]
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_stream_hasher_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Digest predictor with its own chaining state and block buffer
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_len;
        logic [31:0] digest_q [$];
        int          fails;

        function new();
            fails = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = sha_pkg::INIT_VECTOR[i];
            fill = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] wt, t1, t2, s0, s1;
            for (int j = 0; j < 8; j++) v[j] = chain[j];
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
                end else begin
                    s1 = ror(w[(t-2)%16], 17) ^ ror(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
                    s0 = ror(w[(t-15)%16], 7) ^ ror(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
                    wt = s1 + w[(t-7)%16] + s0 + w[t%16];
                end
                w[t%16] = wt;
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::ROUND_K[t] + wt;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) | ((v[0] | v[1]) & v[2]));
                for (int j = 7; j > 0; j--) v[j] = v[j-1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
        endfunction

        // note an accepted input transfer
        function void note_input(logic [7:0] b, logic hb, logic lb);
            if (hb) begin
                blk[fill] = b;
                fill++;
                bit_len = bit_len + 64'd8;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
            end
            if (!lb) return;
            blk[fill] = sha_pkg::PAD_MARK;
            fill++;
            if (fill > 56) begin
                while (fill < 64) blk[fill++] = 8'h00;
                compress();
                fill = 0;
            end
            while (fill < 56) blk[fill++] = 8'h00;
            for (int j = 0; j < 8; j++) blk[56+j] = bit_len[63-8*j -: 8];
            compress();
            for (int j = 0; j < 8; j++) digest_q.push_back(chain[j]);
            restart();
        endfunction

        // check one digest word transfer
        function void check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
            logic [31:0] exp_w;
            logic [2:0]  exp_idx;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time, dw, idx);
                fails++;
                return;
            end
            exp_idx = 3'(8 - digest_q.size() % 8) & 3'h7;
            exp_w = digest_q.pop_front();
            if (dw !== exp_w) begin
                $display("%0t: digest_word exp %h got %h", $time, exp_w, dw);
                fails++;
            end
            if (idx !== exp_idx) begin
                $display("%0t: word_index exp %0d got %0d", $time, exp_idx, idx);
                fails++;
            end
            if (lw !== (exp_idx == sha_pkg::IDX_LAST)) begin
                $display("%0t: last_word exp %0b got %0b", $time,
                         exp_idx == sha_pkg::IDX_LAST, lw);
                fails++;
            end
        endfunction
    endclass

    digest_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int quiet_cycles = 0;
    localparam int QUIET_LIMIT = 20000;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: note input transfers, check output transfers, watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.data_byte, in_ch.has_byte, in_ch.last_byte);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(logic [7:0] b, logic hb, logic lb);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte <= hb;
        in_ch.last_byte <= lb;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // A message of n random bytes; the last byte may carry the end mark
    task automatic send_message(int n);
        bit end_on_byte;
        end_on_byte = (n > 0) && $urandom_range(1);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), 1'b1, end_on_byte && (i == n - 1));
        if (!end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // the first wait lets the monitor note the last transfer before the queue is read
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.digest_q.size() != 0) @(posedge clk);
    endtask

    int sent;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, ignored items, extremes, padding boundaries
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        drain();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        drain();

        // Random messages over the idling phases
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 65) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 65) : 0;
            for (int m = 0; m < 3; m++) begin
                send_message(($urandom_range(7) == 0) ? $urandom_range(60, 130)
                                                      : $urandom_range(0, 12));
                if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            end
            // Receiver holds off while short messages keep coming
            if (ph == 0) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int k = 0; k < 3; k++) send_message($urandom_range(0, 5));
                    end
                join
            end
            // sender pauses until every digest word has come
            drain();
        end

        repeat (100) @(posedge clk);
        if (sb.fails == 0 && sb.digest_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
